// ===== rtl/core/sbc_pkg.sv =====
// Shared types, widths, normal codes and helpers for the swept box collision block.
`timescale 1ns / 1ps
package sbc_pkg;

  localparam int COORD_BITS     = 24;
  localparam int SIZE_BITS      = COORD_BITS - 1;
  localparam int TIME_FRAC_BITS = 16;
  localparam int TIME_BITS      = TIME_FRAC_BITS + 1;
  localparam int MARGIN_BITS    = 8;
  // distances and sums need three bits of headroom over a coordinate
  localparam int DIST_BITS      = COORD_BITS + 3;
  // magnitude of a displacement
  localparam int DEN_BITS       = COORD_BITS;
  localparam int PROD_BITS      = DIST_BITS + DEN_BITS + 1;
  localparam int REM_BITS       = DEN_BITS + 1;
  localparam int DIV_STAGES     = TIME_BITS;
  localparam int FIFO_DEPTH     = 4;

  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = MARGIN_BITS'(1);

  localparam logic [2:0] NRM_NONE    = 3'd0;
  localparam logic [2:0] NRM_PLUS_X  = 3'd1;
  localparam logic [2:0] NRM_MINUS_X = 3'd2;
  localparam logic [2:0] NRM_PLUS_Y  = 3'd3;
  localparam logic [2:0] NRM_MINUS_Y = 3'd4;

  localparam logic signed [DIST_BITS-1:0] SAT_HI = DIST_BITS'((64'd1 << (COORD_BITS - 1)) - 64'd1);
  localparam logic signed [DIST_BITS-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] mover_x;
    logic signed [COORD_BITS-1:0] mover_y;
    logic        [SIZE_BITS-1:0]  mover_width;
    logic        [SIZE_BITS-1:0]  mover_height;
    logic signed [COORD_BITS-1:0] move_dx;
    logic signed [COORD_BITS-1:0] move_dy;
    logic signed [COORD_BITS-1:0] other_x;
    logic signed [COORD_BITS-1:0] other_y;
    logic        [SIZE_BITS-1:0]  other_width;
    logic        [SIZE_BITS-1:0]  other_height;
  } in_item_t;

  typedef struct packed {
    logic                         hit;
    logic        [TIME_BITS-1:0]  entry_time;
    logic        [2:0]            normal_code;
    logic signed [COORD_BITS-1:0] resolved_x;
    logic signed [COORD_BITS-1:0] resolved_y;
  } out_item_t;

  // classified request handed from the front end to the divider
  typedef struct packed {
    logic                         hit;
    logic        [2:0]            code;
    logic        [DEN_BITS-1:0]   num;
    logic        [DEN_BITS-1:0]   den;
    logic signed [COORD_BITS-1:0] rx;
    logic signed [COORD_BITS-1:0] ry;
  } job_t;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [DIST_BITS-1:0] v
  );
    logic signed [DIST_BITS-1:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    if (v < SAT_LO) c = SAT_LO;
    return c[COORD_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/sbc_front.sv =====
// Front end: broadphase, axis times, exact time compares and hit classification.
`timescale 1ns / 1ps
module sbc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sbc_pkg::in_item_t              in_item,
  input  logic [sbc_pkg::MARGIN_BITS-1:0] margin,
  output logic                           push,
  output sbc_pkg::job_t                  push_job,
  input  logic                           fifo_full
);
  import sbc_pkg::*;

  typedef struct packed {
    logic                         bp_miss;
    logic                         xz;
    logic                         yz;
    logic                         xen_neg;
    logic                         yen_neg;
    logic signed [DIST_BITS-1:0]  xe;
    logic signed [DIST_BITS-1:0]  xx;
    logic signed [DIST_BITS-1:0]  ye;
    logic signed [DIST_BITS-1:0]  yx;
    logic        [DEN_BITS-1:0]   xd;
    logic        [DEN_BITS-1:0]   yd;
    logic signed [COORD_BITS-1:0] move_x;
    logic signed [COORD_BITS-1:0] move_y;
    logic signed [COORD_BITS-1:0] x_plus;
    logic signed [COORD_BITS-1:0] x_minus;
    logic signed [COORD_BITS-1:0] y_plus;
    logic signed [COORD_BITS-1:0] y_minus;
  } s1_t;

  logic adv;
  logic s1_v_r, s2_v_r;
  s1_t  s1_r, s1_nxt, s2_r;
  logic signed [PROD_BITS-1:0] p_xe_r, p_ye_r, p_xx_r, p_yx_r;
  logic signed [PROD_BITS-1:0] p_xe_nxt, p_ye_nxt, p_xx_nxt, p_yx_nxt;

  assign adv      = !s2_v_r || !fifo_full;
  assign in_ready = adv;
  assign push     = s2_v_r && !fifo_full;

  // stage 1: sums, broadphase, entry and exit distances
  always_comb begin
    logic signed [DIST_BITS-1:0] mx, my, mw, mh, dx, dy, ox, oy, ow, oh, m;
    logic signed [DIST_BITS-1:0] oxr, oyb, sl, sr, st, sb, xen, xex, yen, yex;
    mx  = DIST_BITS'(in_item.mover_x);
    my  = DIST_BITS'(in_item.mover_y);
    mw  = DIST_BITS'(in_item.mover_width);
    mh  = DIST_BITS'(in_item.mover_height);
    dx  = DIST_BITS'(in_item.move_dx);
    dy  = DIST_BITS'(in_item.move_dy);
    ox  = DIST_BITS'(in_item.other_x);
    oy  = DIST_BITS'(in_item.other_y);
    ow  = DIST_BITS'(in_item.other_width);
    oh  = DIST_BITS'(in_item.other_height);
    m   = DIST_BITS'(margin);
    oxr = ox + ow;
    oyb = oy + oh;
    sl  = (dx > 0) ? mx : mx + dx;
    sr  = (dx > 0) ? mx + dx + mw : mx + mw;
    st  = (dy > 0) ? my : my + dy;
    sb  = (dy > 0) ? my + dy + mh : my + mh;
    xen = (dx > 0) ? ox - (mx + mw) : oxr - mx;
    xex = (dx > 0) ? oxr - mx : ox - (mx + mw);
    yen = (dy > 0) ? oy - (my + mh) : oyb - my;
    yex = (dy > 0) ? oyb - my : oy - (my + mh);
    s1_nxt.bp_miss = (sr <= ox) || (sl >= oxr) || (sb <= oy) || (st >= oyb);
    s1_nxt.xz      = (dx == 0);
    s1_nxt.yz      = (dy == 0);
    s1_nxt.xen_neg = (xen < 0);
    s1_nxt.yen_neg = (yen < 0);
    s1_nxt.xe      = (dx < 0) ? -xen : xen;
    s1_nxt.xx      = (dx < 0) ? -xex : xex;
    s1_nxt.ye      = (dy < 0) ? -yen : yen;
    s1_nxt.yx      = (dy < 0) ? -yex : yex;
    s1_nxt.xd      = (dx < 0) ? DEN_BITS'(-dx) : DEN_BITS'(dx);
    s1_nxt.yd      = (dy < 0) ? DEN_BITS'(-dy) : DEN_BITS'(dy);
    s1_nxt.move_x  = sat_coord(mx + dx);
    s1_nxt.move_y  = sat_coord(my + dy);
    s1_nxt.x_plus  = sat_coord(oxr + m);
    s1_nxt.x_minus = sat_coord(ox - mw - m);
    s1_nxt.y_plus  = sat_coord(oyb + m);
    s1_nxt.y_minus = sat_coord(oy - mh - m);
  end

  // stage 2: cross products for the exact time compares
  always_comb begin
    logic signed [DEN_BITS:0] xds, yds;
    xds      = signed'({1'b0, s1_r.xd});
    yds      = signed'({1'b0, s1_r.yd});
    p_xe_nxt = s1_r.xe * yds;
    p_ye_nxt = s1_r.ye * xds;
    p_xx_nxt = s1_r.xx * yds;
    p_yx_nxt = s1_r.yx * xds;
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
    if (adv) begin
      s1_r   <= s1_nxt;
      s2_r   <= s1_r;
      p_xe_r <= p_xe_nxt;
      p_ye_r <= p_ye_nxt;
      p_xx_r <= p_xx_nxt;
      p_yx_r <= p_yx_nxt;
    end
  end

  // classification: entry/exit selection, miss rules, normal and position
  always_comb begin
    logic e_gt, e_ge, ext_x, ent_gt_ext, both_neg, gt_one, hit;
    logic signed [DIST_BITS-1:0] en_num;
    logic        [DEN_BITS-1:0]  en_den;
    logic        [2:0]           code;
    priority if (s2_r.xz && s2_r.yz) begin
      e_gt = 1'b0; e_ge = 1'b1; ext_x = 1'b1;
    end else if (s2_r.xz) begin
      e_gt = 1'b0; e_ge = 1'b0; ext_x = 1'b0;
    end else if (s2_r.yz) begin
      e_gt = 1'b1; e_ge = 1'b1; ext_x = 1'b1;
    end else begin
      e_gt  = p_xe_r > p_ye_r;
      e_ge  = p_xe_r >= p_ye_r;
      ext_x = p_xx_r <= p_yx_r;
    end
    unique case ({e_ge, ext_x})
      2'b11:   ent_gt_ext = s2_r.xe > s2_r.xx;
      2'b10:   ent_gt_ext = p_xe_r > p_yx_r;
      2'b01:   ent_gt_ext = p_ye_r > p_xx_r;
      default: ent_gt_ext = s2_r.ye > s2_r.yx;
    endcase
    both_neg = (s2_r.xz || s2_r.xe < 0) && (s2_r.yz || s2_r.ye < 0);
    en_num   = e_ge ? s2_r.xe : s2_r.ye;
    en_den   = e_ge ? s2_r.xd : s2_r.yd;
    gt_one   = en_num > signed'(DIST_BITS'(en_den));
    hit      = !s2_r.bp_miss && !ent_gt_ext && !both_neg && !gt_one;
    if (e_gt) code = s2_r.xen_neg ? NRM_PLUS_X : NRM_MINUS_X;
    else      code = s2_r.yen_neg ? NRM_PLUS_Y : NRM_MINUS_Y;
    if (hit) begin
      push_job.hit  = 1'b1;
      push_job.code = code;
      push_job.num  = en_num[DEN_BITS-1:0];
      push_job.den  = en_den;
      unique case (code)
        NRM_PLUS_X:  begin push_job.rx = s2_r.x_plus;  push_job.ry = s2_r.move_y; end
        NRM_MINUS_X: begin push_job.rx = s2_r.x_minus; push_job.ry = s2_r.move_y; end
        NRM_PLUS_Y:  begin push_job.rx = s2_r.move_x;  push_job.ry = s2_r.y_plus; end
        default:     begin push_job.rx = s2_r.move_x;  push_job.ry = s2_r.y_minus; end
      endcase
    end else begin
      push_job.hit  = 1'b0;
      push_job.code = NRM_NONE;
      push_job.num  = '0;
      push_job.den  = DEN_BITS'(1);
      push_job.rx   = '0;
      push_job.ry   = '0;
    end
  end

endmodule

// ===== rtl/core/sbc_fifo.sv =====
// Short request queue between the front end and the divider.
`timescale 1ns / 1ps
module sbc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sbc_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output sbc_pkg::job_t pop_job
);
  import sbc_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);

  job_t            mem_r [FIFO_DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;

  assign full      = (cnt_r == (AW + 1)'(FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_job   = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/sbc_div.sv =====
// Back end: pipelined restoring divider for the entry time, plus the output register.
`timescale 1ns / 1ps
module sbc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               pop,
  input  sbc_pkg::job_t      job,
  output logic               out_valid,
  input  logic               out_ready,
  output sbc_pkg::out_item_t out_item
);
  import sbc_pkg::*;

  typedef struct packed {
    logic                         hit;
    logic        [2:0]            code;
    logic signed [COORD_BITS-1:0] rx;
    logic signed [COORD_BITS-1:0] ry;
  } meta_t;

  logic                  adv;
  logic                  v_r   [DIV_STAGES];
  logic [REM_BITS-1:0]   rem_r [DIV_STAGES];
  logic [DEN_BITS-1:0]   den_r [DIV_STAGES];
  logic [TIME_BITS-1:0]  q_r   [DIV_STAGES];
  meta_t                 meta_r [DIV_STAGES];
  logic                  out_valid_r;
  out_item_t             out_item_r;

  assign adv       = !out_valid_r || out_ready;
  assign pop       = adv && job_valid;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [REM_BITS-1:0]  rem_in, rem_sh, rem_o;
    logic [DEN_BITS-1:0]  den_in;
    logic [TIME_BITS-1:0] q_in;
    meta_t                meta_in;
    logic                 v_in, qbit;
    if (k == 0) begin : g_first
      assign v_in    = pop;
      assign rem_in  = {1'b0, job.num};
      assign den_in  = job.den;
      assign q_in    = '0;
      assign meta_in = '{hit: job.hit, code: job.code, rx: job.rx, ry: job.ry};
      assign rem_sh  = rem_in;
    end else begin : g_rest
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign q_in    = q_r[k-1];
      assign meta_in = meta_r[k-1];
      assign rem_sh  = {rem_in[REM_BITS-2:0], 1'b0};
    end
    assign qbit  = rem_sh >= {1'b0, den_in};
    assign rem_o = qbit ? rem_sh - {1'b0, den_in} : rem_sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_in;
      end
      if (adv) begin
        rem_r[k]  <= rem_o;
        den_r[k]  <= den_in;
        q_r[k]    <= {q_in[TIME_BITS-2:0], qbit};
        meta_r[k] <= meta_in;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[DIV_STAGES-1];
    end
    if (adv) begin
      out_item_r.hit         <= meta_r[DIV_STAGES-1].hit;
      out_item_r.entry_time  <= q_r[DIV_STAGES-1];
      out_item_r.normal_code <= meta_r[DIV_STAGES-1].code;
      out_item_r.resolved_x  <= meta_r[DIV_STAGES-1].rx;
      out_item_r.resolved_y  <= meta_r[DIV_STAGES-1].ry;
    end
  end

endmodule

// ===== rtl/core/swept_box_collision.sv =====
// Top level of the swept 2-D box collision block.
`timescale 1ns / 1ps
// Takes one moving/static box pair per cycle while in_ready is high and returns one
// result per pair, in order. Path: two front-end stages (sums and broadphase, then
// cross products), the request queue, a 17-stage divider that forms the entry time
// one quotient bit per stage, and the output register. Throughput is one pair per clock
// while not stalled; the four-entry queue lets the front end keep accepting while the
// divider side is held by out_ready. cfg_data sets the push-out margin and is always
// accepted; write it only while no request is in flight. Margin resets to 1.
module swept_box_collision (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sbc_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sbc_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sbc_pkg::MARGIN_BITS-1:0] cfg_data
);
  import sbc_pkg::*;

  logic [MARGIN_BITS-1:0] margin_r;
  logic push, fifo_full, pop, fifo_ne;
  job_t push_job, pop_job;

  assign cfg_ready = 1'b1;

  // margin register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RESET;
    end else if (cfg_valid) begin
      margin_r <= cfg_data;
    end
  end

  sbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .margin    (margin_r),
    .push      (push),
    .push_job  (push_job),
    .fifo_full (fifo_full)
  );

  sbc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (fifo_full),
    .pop       (pop),
    .not_empty (fifo_ne),
    .pop_job   (pop_job)
  );

  sbc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (fifo_ne),
    .pop       (pop),
    .job       (pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/core/sbc_checker.sv =====
// Port-level checks for the swept box collision block, bound to the top level.
`timescale 1ns / 1ps
module sbc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input sbc_pkg::out_item_t out_item
);
  import sbc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // a miss reports all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.hit |-> out_item.entry_time == '0 &&
      out_item.normal_code == NRM_NONE && out_item.resolved_x == '0 &&
      out_item.resolved_y == '0)
    else $error("miss with nonzero fields");

  // a hit carries a face normal and a time no later than the end of the step
  a_hit_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.hit |-> out_item.normal_code != NRM_NONE &&
      out_item.normal_code <= NRM_MINUS_Y &&
      out_item.entry_time <= (TIME_BITS'(1) << TIME_FRAC_BITS))
    else $error("hit with bad normal or time");

  // nothing is shown right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind swept_box_collision sbc_checker u_sbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// ===== verif/tb_swept_box_collision.sv =====
// Self-checking testbench for the swept box collision block.
`timescale 1ns / 1ps
module tb_swept_box_collision;
  import sbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 30;

  // exact time value: inf is -1, 0 or +1, otherwise num/den with den > 0
  typedef struct {
    int     inf;
    longint num;
    longint den;
  } span_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  in_item_t  pending_boxes[$];
  out_item_t expected_contacts[$];
  logic [7:0] margin_model;
  logic      hold_requests;
  logic      in_taken;
  int        burst_left;
  int        gap_left;
  int        stall_mode;
  int        stall_count;
  int        idle_cycles;
  int        error_count;

  swept_box_collision i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // three-way compare of two exact times
  function automatic int span_cmp(span_t t, span_t u);
    longint lhs;
    longint rhs;
    if (t.inf != 0 || u.inf != 0) return (t.inf > u.inf) - (t.inf < u.inf);
    lhs = t.num * u.den;
    rhs = u.num * t.den;
    return (lhs > rhs) - (lhs < rhs);
  endfunction

  function automatic void axis_span(input longint d_en, input longint d_ex,
                                    input longint v, output span_t en, output span_t ex);
    if (v == 0) begin
      en = '{-1, 0, 1};
      ex = '{1, 0, 1};
    end else if (v < 0) begin
      en = '{0, -d_en, -v};
      ex = '{0, -d_ex, -v};
    end else begin
      en = '{0, d_en, v};
      ex = '{0, d_ex, v};
    end
  endfunction

  function automatic logic signed [23:0] clamp_coord(longint v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // swept test of one box pair, margin m
  function automatic out_item_t predict_contact(in_item_t it, logic [7:0] m);
    longint mx, my, mw, mh, dx, dy, ox, oy, ow, oh;
    longint bx, by, bw, bh, xen, xex, yen, yex, rx, ry, mg, q;
    span_t txe, txx, tye, tyx, ent, ext, zero, one;
    logic [2:0] code;
    out_item_t r;
    mx = longint'(it.mover_x);  my = longint'(it.mover_y);
    mw = longint'(it.mover_width);  mh = longint'(it.mover_height);
    dx = longint'(it.move_dx);  dy = longint'(it.move_dy);
    ox = longint'(it.other_x);  oy = longint'(it.other_y);
    ow = longint'(it.other_width);  oh = longint'(it.other_height);
    mg = longint'(m);
    r = '0;
    // broadphase: swept box must overlap, touching is no overlap
    bx = dx > 0 ? mx : mx + dx;
    by = dy > 0 ? my : my + dy;
    bw = dx > 0 ? dx + mw : mw - dx;
    bh = dy > 0 ? dy + mh : mh - dy;
    if (bx + bw <= ox || bx >= ox + ow || by + bh <= oy || by >= oy + oh) return r;
    if (dx > 0) begin xen = ox - (mx + mw); xex = (ox + ow) - mx; end
    else begin xen = (ox + ow) - mx; xex = ox - (mx + mw); end
    if (dy > 0) begin yen = oy - (my + mh); yex = (oy + oh) - my; end
    else begin yen = (oy + oh) - my; yex = oy - (my + mh); end
    axis_span(xen, xex, dx, txe, txx);
    axis_span(yen, yex, dy, tye, tyx);
    ent = span_cmp(txe, tye) >= 0 ? txe : tye;
    ext = span_cmp(txx, tyx) <= 0 ? txx : tyx;
    zero = '{0, 0, 1};
    one = '{0, 1, 1};
    if (span_cmp(ent, ext) > 0 || (span_cmp(txe, zero) < 0 && span_cmp(tye, zero) < 0) ||
        span_cmp(ent, one) > 0) return r;
    if (span_cmp(txe, tye) > 0) code = xen < 0 ? NRM_PLUS_X : NRM_MINUS_X;
    else code = yen < 0 ? NRM_PLUS_Y : NRM_MINUS_Y;
    case (code)
      NRM_PLUS_Y: begin rx = mx + dx; ry = oy + oh + mg; end
      NRM_MINUS_Y: begin rx = mx + dx; ry = oy - mh - mg; end
      NRM_PLUS_X: begin rx = ox + ow + mg; ry = my + dy; end
      default: begin rx = ox - mw - mg; ry = my + dy; end
    endcase
    q = (ent.num << TIME_FRAC_BITS) / ent.den;
    r.hit = 1'b1;
    r.entry_time = q[TIME_BITS-1:0];
    r.normal_code = code;
    r.resolved_x = clamp_coord(rx);
    r.resolved_y = clamp_coord(ry);
    return r;
  endfunction

  function automatic in_item_t make_pair(longint mx, longint my, longint mw, longint mh,
                                         longint dx, longint dy, longint ox, longint oy,
                                         longint ow, longint oh);
    in_item_t it;
    it.mover_x = mx[23:0];  it.mover_y = my[23:0];
    it.mover_width = mw[22:0];  it.mover_height = mh[22:0];
    it.move_dx = dx[23:0];  it.move_dy = dy[23:0];
    it.other_x = ox[23:0];  it.other_y = oy[23:0];
    it.other_width = ow[22:0];  it.other_height = oh[22:0];
    return it;
  endfunction

  function automatic longint spread(int span);
    return longint'($urandom_range(2 * span)) - span;
  endfunction

  // mostly pairs placed near each other so contacts are common, some raw noise
  function automatic in_item_t random_pair();
    in_item_t it;
    logic [255:0] raw;
    longint ox, oy;
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(in_item_t)-1:0];
      return it;
    end
    ox = spread(sel < 25 ? 8388000 : 200000);
    oy = spread(sel < 25 ? 8388000 : 200000);
    it = make_pair(ox + spread(6000), oy + spread(6000), $urandom_range(3000),
                   $urandom_range(3000), spread(14000), spread(14000), ox, oy,
                   $urandom_range(3000), $urandom_range(3000));
    if (sel >= 90) it.move_dx = '0;
    else if (sel >= 82) it.move_dy = '0;
    return it;
  endfunction

  // requests the block must handle, queued again before each run
  task automatic load_directed();
    pending_boxes.push_back('0);
    pending_boxes.push_back(make_pair(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                                      8388607, 8388607, 8388607, 8388607));
    pending_boxes.push_back(make_pair(-8388608, -8388608, 0, 0, -8388608, -8388608,
                                      -8388608, -8388608, 0, 0));
    // overlapping but not moving
    pending_boxes.push_back(make_pair(0, 0, 512, 512, 0, 0, 100, 100, 512, 512));
    // each face, moving straight in
    pending_boxes.push_back(make_pair(-2000, 0, 256, 256, 4000, 0, 0, 0, 512, 512));
    pending_boxes.push_back(make_pair(3000, 0, 256, 256, -4000, 0, 0, 0, 512, 512));
    pending_boxes.push_back(make_pair(0, -2000, 256, 256, 0, 4000, 0, 0, 512, 512));
    pending_boxes.push_back(make_pair(0, 3000, 256, 256, 0, -4000, 0, 0, 512, 512));
    // diagonal approach
    pending_boxes.push_back(make_pair(-1000, -700, 256, 256, 3000, 2500, 0, 0, 512, 512));
    // already touching, entry time zero
    pending_boxes.push_back(make_pair(-256, 0, 256, 256, 100, 0, 0, 0, 512, 512));
    // arrives exactly at the end of the step
    pending_boxes.push_back(make_pair(-1256, 0, 256, 256, 1000, 0, 0, 0, 512, 512));
    // stops just short, sweeps past sideways, edges only touch
    pending_boxes.push_back(make_pair(-1257, 0, 256, 256, 1000, 0, 0, 0, 512, 512));
    pending_boxes.push_back(make_pair(-2000, 600, 256, 256, 4000, 0, 0, 0, 512, 512));
    pending_boxes.push_back(make_pair(-2000, 512, 256, 256, 4000, 0, 0, 0, 512, 512));
    // moving away from an overlap
    pending_boxes.push_back(make_pair(100, 100, 256, 256, -4000, -4000, 0, 0, 512, 512));
    // saturating push-out at both ends
    pending_boxes.push_back(make_pair(8300000, 0, 256, 256, -100000, 0, 8000000, 0,
                                      8388607, 512));
    pending_boxes.push_back(make_pair(-8300000, 0, 8000000, 256, 100000, 0, -8000000, 0,
                                      512, 512));
    pending_boxes.push_back(make_pair(0, -8388000, 256, 4000000, 0, 100000, 0, -4300000,
                                      512, 512));
    pending_boxes.push_back(make_pair(0, 8380000, 256, 256, 0, -200000, 0, 8000000, 512,
                                      8388607));
  endtask

  // request driver: bursts with random gaps
  always @(negedge clk) begin
    logic nv;
    if (rst_n && !(in_valid && !in_taken)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (!hold_requests && pending_boxes.size() > 0) begin
        nv = 1'b1;
        in_item <= pending_boxes.pop_front();
        if (burst_left == 0) begin
          burst_left = $urandom_range(40);
          gap_left = $urandom_range(1) ? 0 : $urandom_range(6);
        end else begin
          burst_left--;
        end
      end
      in_valid <= nv;
    end
  end

  // result receiver stalls in random modes, a new one picked each time stall_count wraps
  always @(negedge clk) begin
    if (stall_count == 0) stall_mode = $urandom_range(3);
    stall_count = (stall_count + 1) % 64;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(1));
      2: out_ready <= (stall_count % 8) < 2;
      default: out_ready <= $urandom_range(3) != 0;
    endcase
  end

  // prediction at acceptance, checking against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) margin_model <= cfg_data;
      if (in_valid && in_ready)
        expected_contacts.push_back(predict_contact(in_item, margin_model));
      if (out_valid && out_ready) begin
        if (expected_contacts.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item);
          error_count++;
        end else begin
          want = expected_contacts.pop_front();
          if (want.hit !== out_item.hit || want.entry_time !== out_item.entry_time ||
              want.normal_code !== out_item.normal_code ||
              want.resolved_x !== out_item.resolved_x ||
              want.resolved_y !== out_item.resolved_y) begin
            $display("%0t: mismatch expected hit=%0d t=%0d n=%0d x=%0d y=%0d", $time,
                     want.hit, want.entry_time, want.normal_code, want.resolved_x,
                     want.resolved_y);
            $display("%0t:          actual   hit=%0d t=%0d n=%0d x=%0d y=%0d", $time,
                     out_item.hit, out_item.entry_time, out_item.normal_code,
                     out_item.resolved_x, out_item.resolved_y);
            error_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic write_margin(logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // send every queued request, wait until every result is back, then let the pipe settle
  task automatic drain_pipe();
    do @(posedge clk);
    while (pending_boxes.size() > 0 || in_valid || expected_contacts.size() > 0);
    hold_requests = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [7:0] margin_plan[5];
    margin_plan = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd0};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    out_ready = 1'b0;
    margin_model = MARGIN_RESET;
    hold_requests = 1'b1;
    in_taken = 1'b0;
    burst_left = 0;
    gap_left = 0;
    stall_mode = 0;
    stall_count = 0;
    idle_cycles = 0;
    error_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // reset margin first, then each planned setting
    load_directed();
    hold_requests = 1'b0;
    drain_pipe();
    foreach (margin_plan[p]) begin
      write_margin(p == 3 ? 8'($urandom_range(2, 254)) : margin_plan[p]);
      load_directed();
      repeat (187) pending_boxes.push_back(random_pair());
      hold_requests = 1'b0;
      drain_pipe();
    end
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
